@@ hdl/qoid_pkg.sv @@
// Shared types and constants of the draft QOI pixel decoder.
package qoid_pkg;

  // Color index geometry
  localparam int unsigned IndexEntries = 64;
  localparam int unsigned IndexAddrW   = $clog2(IndexEntries);

  // Configuration port geometry and register indexes
  localparam int unsigned CfgAddrW  = 3;
  localparam logic        RegWidth  = 1'b0;
  localparam logic        RegHeight = 1'b1;

  // Opcode masks and codes
  localparam logic [7:0] MaskTop2   = 8'hC0;
  localparam logic [7:0] MaskTop3   = 8'hE0;
  localparam logic [7:0] MaskTop4   = 8'hF0;
  localparam logic [7:0] CodeIndex  = 8'h00;
  localparam logic [7:0] CodeRun8   = 8'h40;
  localparam logic [7:0] CodeRun16  = 8'h60;
  localparam logic [7:0] CodeDiff8  = 8'h80;
  localparam logic [7:0] CodeDiff16 = 8'hC0;
  localparam logic [7:0] CodeDiff24 = 8'hE0;
  localparam logic [7:0] CodeColor  = 8'hF0;

  // Long run offset and start-of-image pixel
  localparam logic [13:0] RunBias    = 14'd32;
  localparam logic [31:0] PixelReset = 32'h0000_00FF;

  // Kind of opcode that a byte opens
  typedef enum logic [2:0] {
    OP_INDEX,
    OP_RUN8,
    OP_RUN16,
    OP_DIFF8,
    OP_DIFF16,
    OP_DIFF24,
    OP_COLOR
  } op_e;

  // Classified byte as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    op_e        op;
    logic [2:0] extra;  // bytes that follow when this byte opens an opcode
  } qe_t;

  // New image request from the configuration port
  typedef struct packed {
    logic        start;
    logic [31:0] total;
  } start_t;

endpackage

@@ hdl/qoi_draft_pixel_decoder.sv @@
// Path: a byte passes the queue and the lookup stage; its result leaves the output register.
// Throughput: one payload byte per cycle while the output accepts; the second result of a
// clean end of data waits in a pending register and holds execution until it is output.
// Reset: image 1x1, current pixel (0,0,0,255), color index empty, queue empty.
// A register write restarts the image through a registered start request and total.
// Top level of the draft QOI pixel decoder.
module qoi_draft_pixel_decoder #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // payload in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] payload_byte
  input  logic                          s_axis_tlast,   // end_of_data
  // pixels out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // red, green, blue, alpha, repeat_count
  output logic                          m_axis_tlast,   // image_done
  output logic                          m_axis_tuser,   // status
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qoid_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  qoid_pkg::start_t start;
  qoid_pkg::qe_t    head;
  logic             head_valid;
  logic             pop;

  qoid_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start_o (start)
  );

  qoid_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  qoid_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_last_o     (m_axis_tlast),
    .m_user_o     (m_axis_tuser)
  );

endmodule

@@ hdl/qoid_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module qoid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/qoid_cfg.sv @@
// Configuration registers and new-image request of the draft QOI decoder.
module qoid_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qoid_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output qoid_pkg::start_t              start_o
);

  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        start_q;
  logic [31:0] total_q;
  logic        wr;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr      = psel && penable && pwrite && pready;

  // Select new dimensions for the request
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (reg_sel == qoid_pkg::RegWidth) begin
      width_d = pwdata[15:0];
    end else begin
      height_d = pwdata[15:0];
    end
  end

  // Hold registers and issue a start request after each write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
      start_q  <= 1'b0;
    end else begin
      start_q <= wr;
      if (wr) begin
        width_q  <= width_d;
        height_q <= height_d;
      end
    end
  end

  // Register the pixel total of the new image
  always_ff @(posedge clk_i) begin
    if (wr) begin
      total_q <= {16'h0, width_d} * {16'h0, height_d};
    end
  end

  assign start_o.start = start_q;
  assign start_o.total = total_q;

  // Read back
  assign prdata = {16'h0, (reg_sel == qoid_pkg::RegHeight) ? height_q : width_q};

endmodule

@@ hdl/qoid_front.sv @@
// Front end: accepts payload bytes, classifies them and queues them.
module qoid_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_data_i,
  input  logic          in_last_i,
  output logic          head_valid_o,
  output qoid_pkg::qe_t head_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  qoid_pkg::qe_t   mem_q [DEPTH];
  qoid_pkg::qe_t   entry;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            do_pop;

  assign in_ready_o   = (count_q != FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Classify the byte as the opener of an opcode
  always_comb begin
    entry.data  = in_data_i;
    entry.eod   = in_last_i;
    entry.op    = qoid_pkg::OP_COLOR;
    entry.extra = 3'd0;
    if ((in_data_i & qoid_pkg::MaskTop2) == qoid_pkg::CodeIndex) begin
      entry.op = qoid_pkg::OP_INDEX;
    end else if ((in_data_i & qoid_pkg::MaskTop3) == qoid_pkg::CodeRun8) begin
      entry.op = qoid_pkg::OP_RUN8;
    end else if ((in_data_i & qoid_pkg::MaskTop3) == qoid_pkg::CodeRun16) begin
      entry.op    = qoid_pkg::OP_RUN16;
      entry.extra = 3'd1;
    end else if ((in_data_i & qoid_pkg::MaskTop2) == qoid_pkg::CodeDiff8) begin
      entry.op = qoid_pkg::OP_DIFF8;
    end else if ((in_data_i & qoid_pkg::MaskTop3) == qoid_pkg::CodeDiff16) begin
      entry.op    = qoid_pkg::OP_DIFF16;
      entry.extra = 3'd1;
    end else if ((in_data_i & qoid_pkg::MaskTop4) == qoid_pkg::CodeDiff24) begin
      entry.op    = qoid_pkg::OP_DIFF24;
      entry.extra = 3'd2;
    end else begin
      entry.op    = qoid_pkg::OP_COLOR;
      entry.extra = {2'b0, in_data_i[0]} + {2'b0, in_data_i[1]}
                  + {2'b0, in_data_i[2]} + {2'b0, in_data_i[3]};
    end
  end

  // Store queued bytes
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ hdl/qoid_back.sv @@
// Back end: index lookup, opcode execution, pixel accounting and result output.
module qoid_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qoid_pkg::start_t start_i,
  input  logic             head_valid_i,
  input  qoid_pkg::qe_t    head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [63:0]      m_data_o,
  output logic             m_last_o,
  output logic             m_user_o
);

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] cnt;
    logic        done;
    logic        err;
  } res_t;

  localparam int unsigned AW = qoid_pkg::IndexAddrW;

  function automatic logic [7:0] sx2(logic [1:0] d);
    return {{6{d[1]}}, d};
  endfunction

  function automatic logic [7:0] sx4(logic [3:0] d);
    return {{4{d[3]}}, d};
  endfunction

  function automatic logic [7:0] sx5(logic [4:0] d);
    return {{3{d[4]}}, d};
  endfunction

  // Lookup stage
  qoid_pkg::qe_t l_q;
  logic          l_valid_q;
  logic          lvld_q;
  logic          fwd_hit_q;
  logic [31:0]   fwd_data_q;
  logic [31:0]   rdata;
  logic [31:0]   idx_px;

  // Decoder state
  logic [31:0] cur_q;
  logic [7:0]  first_q, first_n;
  logic [15:0] low_q, low_n;
  logic [2:0]  need_q, need_n;
  logic [31:0] rem_q;
  logic        fin_q;
  logic [qoid_pkg::IndexEntries-1:0] vld_q;

  // Output side
  logic out_valid_q;
  res_t out_q;
  logic pend2_q;
  res_t pend_q;
  logic out_free;
  logic exec_fire;

  // Execution signals
  logic [7:0]    r_n, g_n, b_n, a_n;
  logic [31:0]   px_n;
  logic          complete;
  logic [13:0]   run;
  logic [13:0]   cnt_raw;
  logic [31:0]   cnt;
  logic [31:0]   rem_left;
  logic          fin1;
  logic          has_res;
  logic          needs2;
  res_t          r1, r2;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign out_free  = !out_valid_q || m_ready_i;
  assign exec_fire = l_valid_q && !pend2_q && out_free;
  assign pop_o     = head_valid_i && (!l_valid_q || exec_fire);
  assign raddr     = head_i.data[AW-1:0];

  qoid_ram #(
    .WIDTH (32),
    .DEPTH (qoid_pkg::IndexEntries)
  ) u_index (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (px_n),
    .re_i    (pop_o),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Pick the index entry: a write in the read cycle wins, unwritten reads zero
  assign idx_px = fwd_hit_q ? fwd_data_q : (lvld_q ? rdata : 32'h0);

  // Execute the byte in the lookup stage
  always_comb begin
    r_n      = cur_q[31:24];
    g_n      = cur_q[23:16];
    b_n      = cur_q[15:8];
    a_n      = cur_q[7:0];
    first_n  = first_q;
    low_n    = low_q;
    need_n   = need_q;
    complete = 1'b0;
    run      = 14'd0;
    if (need_q == 3'd0) begin
      first_n = l_q.data;
      low_n   = 16'h0;
      need_n  = l_q.extra;
      case (l_q.op)
        qoid_pkg::OP_INDEX: begin
          {r_n, g_n, b_n, a_n} = idx_px;
          complete = 1'b1;
        end
        qoid_pkg::OP_RUN8: begin
          run      = {9'b0, l_q.data[4:0]};
          complete = 1'b1;
        end
        qoid_pkg::OP_DIFF8: begin
          r_n      = cur_q[31:24] + sx2(l_q.data[5:4]);
          g_n      = cur_q[23:16] + sx2(l_q.data[3:2]);
          b_n      = cur_q[15:8] + sx2(l_q.data[1:0]);
          complete = 1'b1;
        end
        qoid_pkg::OP_COLOR: begin
          low_n    = {12'h0, l_q.data[3:0]};
          complete = (l_q.extra == 3'd0);
        end
        default: begin
          complete = 1'b0;
        end
      endcase
    end else begin
      if ((first_q & qoid_pkg::MaskTop4) == qoid_pkg::CodeColor) begin
        // fill the highest flagged channel first
        if (low_q[3]) begin
          r_n      = l_q.data;
          low_n[3] = 1'b0;
        end else if (low_q[2]) begin
          g_n      = l_q.data;
          low_n[2] = 1'b0;
        end else if (low_q[1]) begin
          b_n      = l_q.data;
          low_n[1] = 1'b0;
        end else begin
          a_n      = l_q.data;
          low_n[0] = 1'b0;
        end
      end else begin
        low_n = {low_q[7:0], l_q.data};
      end
      need_n = need_q - 3'd1;
      if (need_n == 3'd0) begin
        complete = 1'b1;
        if ((first_q & qoid_pkg::MaskTop3) == qoid_pkg::CodeRun16) begin
          run = {1'b0, first_q[4:0], l_q.data} + qoid_pkg::RunBias;
        end else if ((first_q & qoid_pkg::MaskTop3) == qoid_pkg::CodeDiff16) begin
          r_n = cur_q[31:24] + sx5(first_q[4:0]);
          g_n = cur_q[23:16] + sx4(l_q.data[7:4]);
          b_n = cur_q[15:8] + sx4(l_q.data[3:0]);
        end else if ((first_q & qoid_pkg::MaskTop4) == qoid_pkg::CodeDiff24) begin
          r_n = cur_q[31:24] + sx5({first_q[3:0], low_q[7]});
          g_n = cur_q[23:16] + sx5(low_q[6:2]);
          b_n = cur_q[15:8] + sx5({low_q[1:0], l_q.data[7:5]});
          a_n = cur_q[7:0] + sx5(l_q.data[4:0]);
        end
      end
    end
  end

  // Clip the repeat count to the pixels still owed
  assign px_n     = {r_n, g_n, b_n, a_n};
  assign cnt_raw  = run + 14'd1;
  assign cnt      = ({18'b0, cnt_raw} > rem_q) ? rem_q : {18'b0, cnt_raw};
  assign rem_left = rem_q - cnt;
  assign fin1     = (rem_left == 32'h0);
  assign has_res  = !fin_q && (complete || l_q.eod);
  assign needs2   = complete && l_q.eod && !fin1;
  assign we       = exec_fire && !fin_q && complete;
  assign waddr    = r_n[AW-1:0] ^ g_n[AW-1:0] ^ b_n[AW-1:0] ^ a_n[AW-1:0];

  // Build the results of this byte
  always_comb begin
    if (complete) begin
      r1 = '{px: px_n, cnt: cnt, done: fin1, err: 1'b0};
    end else begin
      r1 = '{px: 32'h0, cnt: 32'h0, done: 1'b0, err: 1'b1};
    end
    r2 = '{px: px_n, cnt: rem_left, done: 1'b1, err: 1'b0};
  end

  // Hold lookup stage and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
      cur_q     <= qoid_pkg::PixelReset;
      first_q   <= 8'h0;
      low_q     <= 16'h0;
      need_q    <= 3'd0;
      rem_q     <= 32'd1;
      fin_q     <= 1'b0;
      vld_q     <= '0;
    end else begin
      if (pop_o) begin
        l_valid_q <= 1'b1;
      end else if (exec_fire) begin
        l_valid_q <= 1'b0;
      end
      if (start_i.start) begin
        cur_q   <= qoid_pkg::PixelReset;
        first_q <= 8'h0;
        low_q   <= 16'h0;
        need_q  <= 3'd0;
        rem_q   <= start_i.total;
        fin_q   <= (start_i.total == 32'h0);
        vld_q   <= '0;
      end else if (exec_fire && !fin_q) begin
        cur_q <= px_n;
        if (complete) begin
          first_q      <= first_n;
          low_q        <= low_n;
          need_q       <= need_n;
          vld_q[waddr] <= 1'b1;
          rem_q        <= needs2 ? 32'h0 : rem_left;
          fin_q        <= fin1 || l_q.eod;
        end else if (l_q.eod) begin
          first_q <= 8'h0;
          low_q   <= 16'h0;
          need_q  <= 3'd0;
          fin_q   <= 1'b1;
        end else begin
          first_q <= first_n;
          low_q   <= low_n;
          need_q  <= need_n;
        end
      end
    end
  end

  // Capture the popped byte and a same-cycle index write for forwarding
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      l_q        <= head_i;
      lvld_q     <= vld_q[raddr];
      fwd_hit_q  <= we && (waddr == raddr);
      fwd_data_q <= px_n;
    end
  end

  // Advance the output register and the pending second result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend2_q     <= 1'b0;
    end else if (out_free) begin
      if (pend2_q) begin
        out_valid_q <= 1'b1;
        pend2_q     <= 1'b0;
      end else if (exec_fire && has_res) begin
        out_valid_q <= 1'b1;
        pend2_q     <= needs2;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load result payloads
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend2_q) begin
        out_q <= pend_q;
      end else if (exec_fire && has_res) begin
        out_q  <= r1;
        pend_q <= r2;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {out_q.cnt, out_q.px[7:0], out_q.px[15:8], out_q.px[23:16],
                      out_q.px[31:24]};
  assign m_last_o  = out_q.done;
  assign m_user_o  = out_q.err;

endmodule
